// ----- hdl/bac_pkg.sv -----
// shared constants, types and the thermistor table of the battery adc converter
`timescale 1ns / 1ps
package bac_pkg;

  localparam int OpW        = 2;
  localparam int SampleW    = 10;
  localparam int ValueW     = 14;
  localparam int ConvW      = 13;
  localparam int ScaleShift = 20;
  localparam int ScaleW     = 23;
  localparam int ProdW      = SampleW + ScaleW;

  // reciprocal scale factors, value = (sample * scale) >> ScaleShift
  localparam logic [ScaleW-1:0] ScaleVoltage     = 23'd6165627;  // 588/100
  localparam logic [ScaleW-1:0] ScaleCurrent     = 23'd878205;   // 1000/1194
  localparam logic [ScaleW-1:0] ScaleCurrentHalf = 23'd439103;   // 1000/2388
  localparam logic [ScaleW-1:0] ScaleTemp        = 23'd1541407;  // 147/100

  // resistance = mv * 1000 / ((code + 1) * 10) = mv * 100 / (code + 1)
  localparam int MvToRes = 100;

  localparam int DivW  = 18;
  localparam int DenW  = 4;
  localparam int RemW  = 3;
  localparam int BiasW = 3;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 3;
  localparam logic [CfgIdxW-1:0] REG_RANGE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_BIAS  = 1'd1;

  localparam int TempTableEntries = 59;
  localparam int TableSlots       = 64;
  localparam int TableIdxW        = 6;
  localparam int TableW           = 15;

  localparam logic [TableW-1:0] ThermTable [TableSlots] = '{
    15'd30800, 15'd29500, 15'd28300, 15'd27100, 15'd26000, 15'd24900, 15'd23900, 15'd22900,
    15'd22000, 15'd21100, 15'd20300, 15'd19400, 15'd18700, 15'd17900, 15'd17200, 15'd16500,
    15'd15900, 15'd15300, 15'd14700, 15'd14100, 15'd13600, 15'd13100, 15'd12600, 15'd12100,
    15'd11600, 15'd11200, 15'd10800, 15'd10400, 15'd10000, 15'd9630,  15'd9280,  15'd8950,
    15'd8620,  15'd8310,  15'd8020,  15'd7730,  15'd7460,  15'd7200,  15'd6950,  15'd6710,
    15'd6470,  15'd6250,  15'd6040,  15'd5830,  15'd5640,  15'd5450,  15'd5260,  15'd5090,
    15'd4920,  15'd4760,  15'd4600,  15'd4450,  15'd4310,  15'd4170,  15'd4040,  15'd3910,
    15'd3790,  15'd3670,  15'd3550,  15'd0,     15'd0,     15'd0,     15'd0,     15'd0
  };

  typedef enum logic [OpW-1:0] {
    OP_VOLTAGE = 2'd0,
    OP_CURRENT = 2'd1,
    OP_TEMP    = 2'd2
  } op_e;

  // word handed from cell to cell along the divider row
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ConvW-1:0] conv;
    logic [DivW-1:0]  dq;
    logic [RemW-1:0]  rem;
  } div_word_t;

endpackage

// ----- hdl/bac_if.sv -----
// item channels of the battery adc converter
`timescale 1ns / 1ps
interface bac_in_if import bac_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     op;
  logic [SampleW-1:0] sample;

  modport source (output valid, op, sample, input ready);
  modport sink   (input valid, op, sample, output ready);
endinterface

interface bac_out_if import bac_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

// ----- hdl/bac_front.sv -----
// front stage: reciprocal scaling of the sample and divider operand setup
`timescale 1ns / 1ps
module bac_front import bac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               range_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               valid_o,
  input  logic               ready_i,
  output div_word_t          data_o
);

  logic [ScaleW-1:0] scale;
  logic [ProdW-1:0]  prod;
  logic              valid_q;
  logic [OpW-1:0]    op_q;
  logic [ConvW-1:0]  conv_q;
  logic [ConvW-1:0]  conv_d;

  always_comb begin
    case (op_i)
      OP_VOLTAGE: scale = ScaleVoltage;
      OP_CURRENT: scale = range_i ? ScaleCurrentHalf : ScaleCurrent;
      OP_TEMP:    scale = ScaleTemp;
      default:    scale = '0;
    endcase
  end

  assign prod    = ProdW'(sample_i) * ProdW'(scale);
  assign conv_d  = prod[ScaleShift +: ConvW];
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      op_q   <= op_i;
      conv_q <= conv_d;
    end
  end

  assign valid_o     = valid_q;
  assign data_o.op   = op_q;
  assign data_o.conv = conv_q;
  assign data_o.dq   = DivW'(conv_q * MvToRes);
  assign data_o.rem  = '0;

endmodule

// ----- hdl/bac_div_cell.sv -----
// one restoring division cell: one quotient bit per cell
`timescale 1ns / 1ps
module bac_div_cell import bac_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DenW-1:0] den_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  div_word_t       data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output div_word_t       data_o
);

  logic      valid_q;
  div_word_t data_q;
  div_word_t data_d;
  logic [DenW-1:0] shifted;
  logic [DenW-1:0] diff;
  logic            qbit;

  // bring down the next dividend bit, subtract when it fits
  assign shifted = {data_i.rem, data_i.dq[DivW-1]};
  assign diff    = shifted - den_i;
  assign qbit    = (shifted >= den_i);

  always_comb begin
    data_d      = data_i;
    data_d.dq   = {data_i.dq[DivW-2:0], qbit};
    data_d.rem  = qbit ? diff[RemW-1:0] : shifted[RemW-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hdl/bac_back.sv -----
// back stages: thermistor table compare, top-down search and output register
`timescale 1ns / 1ps
module bac_back import bac_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  div_word_t                data_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [ValueW-1:0] value_o
);

  logic                        cmp_valid_q;
  logic [OpW-1:0]              cmp_op_q;
  logic [ConvW-1:0]            cmp_conv_q;
  logic [TempTableEntries-1:0] hit_q;
  logic [TempTableEntries-1:0] hit_d;
  logic                        cmp_ready;

  logic                        out_valid_q;
  logic signed [ValueW-1:0]    value_q;
  logic signed [ValueW-1:0]    value_d;
  logic signed [ValueW-1:0]    temp_val;
  logic [TableIdxW-1:0]        idx;
  logic                        found;

  always_comb begin
    for (int i = 0; i < TempTableEntries; i++) begin
      hit_d[i] = (DivW'(ThermTable[i]) >= data_i.dq);
    end
  end

  assign cmp_ready = !out_valid_q || ready_i;
  assign ready_o   = !cmp_valid_q || cmp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        cmp_valid_q <= valid_i;
      end
      if (cmp_ready) begin
        out_valid_q <= cmp_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      cmp_op_q   <= data_i.op;
      cmp_conv_q <= data_i.conv;
      hit_q      <= hit_d;
    end
    if (cmp_ready) begin
      value_q <= value_d;
    end
  end

  // highest index whose entry still covers the resistance
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < TempTableEntries; i++) begin
      if (hit_q[i]) begin
        found = 1'b1;
        idx   = TableIdxW'(i);
      end
    end
  end

  always_comb begin
    if (!found || idx == TableIdxW'(0)) begin
      temp_val = -ValueW'(2);
    end else if (idx == TableIdxW'(1)) begin
      temp_val = -ValueW'(1);
    end else if (idx == TableIdxW'(2)) begin
      temp_val = '0;
    end else begin
      temp_val = ValueW'(idx) + ValueW'(1);
    end
  end

  always_comb begin
    case (cmp_op_q)
      OP_VOLTAGE: value_d = ValueW'(cmp_conv_q);
      OP_CURRENT: value_d = ValueW'(cmp_conv_q);
      OP_TEMP:    value_d = temp_val;
      default:    value_d = '0;
    endcase
  end

  assign valid_o = out_valid_q;
  assign value_o = value_q;

endmodule

// ----- hdl/battery_adc_converter_unit.sv -----
// top level of the battery adc converter
`timescale 1ns / 1ps
// Converts raw 10-bit battery-monitor samples into millivolts (op 0), milliamps
// (op 1) or degrees Celsius (op 2); op 3 gives 0. The unit takes one item per
// clock and hands back one result per item, in order, once it has passed through
// one scaling stage (a single sample-by-reciprocal multiply), a row
// of 18 restoring division cells that turn the temperature millivolts into
// a thermistor resistance, one compare stage against the 59-entry table and
// the output register. Every stage holds its item while the next one is full,
// so a stalled output only blocks input once all stages are occupied. The two
// configuration registers (current range, bias current code) must only be
// written while no item is in flight.
module battery_adc_converter_unit import bac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  bac_in_if.sink              in_i,
  bac_out_if.source           out_o
);

  // configuration registers
  logic             range_q;
  logic [BiasW-1:0] bias_q;
  logic [DenW-1:0]  den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 1'b0;
      bias_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RANGE: range_q <= cfg_wdata_i[0];
        REG_BIAS:  bias_q  <= cfg_wdata_i[BiasW-1:0];
        default:   ;
      endcase
    end
  end

  // divisor of the resistance step is the bias code plus one
  assign den = DenW'(bias_q) + DenW'(1);

  // pipeline links: index 0 leaves the front stage, index DivW leaves the row
  logic [DivW:0] link_valid;
  logic [DivW:0] link_ready;
  div_word_t     link_data [DivW+1];

  bac_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .range_i  (range_q),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .op_i     (in_i.op),
    .sample_i (in_i.sample),
    .valid_o  (link_valid[0]),
    .ready_i  (link_ready[0]),
    .data_o   (link_data[0])
  );

  // one quotient bit per cell, msb first
  for (genvar k = 0; k < DivW; k++) begin : g_cell
    bac_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .den_i   (den),
      .valid_i (link_valid[k]),
      .ready_o (link_ready[k]),
      .data_i  (link_data[k]),
      .valid_o (link_valid[k+1]),
      .ready_i (link_ready[k+1]),
      .data_o  (link_data[k+1])
    );
  end

  // table search and output register
  bac_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[DivW]),
    .ready_o (link_ready[DivW]),
    .data_i  (link_data[DivW]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .value_o (out_o.value)
  );

endmodule
